### sv/ccms_pkg.sv
package ccms_pkg;

    localparam int LINE_BITS = 24;
    localparam int LINE_NUM_BITS = 24;
    localparam int POS_BITS = 5;
    localparam int IDX_BITS = 4;

    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_BSLASH = 8'h5c;

    localparam logic KIND_IGNORE = 1'b0;
    localparam logic KIND_NOLINT = 1'b1;

    typedef enum logic [8:0] {
        CTX_CODE    = 9'b000000001,
        CTX_STR     = 9'b000000010,
        CTX_STR_ESC = 9'b000000100,
        CTX_CHR     = 9'b000001000,
        CTX_CHR_ESC = 9'b000010000,
        CTX_SLASH   = 9'b000100000,
        CTX_LINE    = 9'b001000000,
        CTX_BLOCK   = 9'b010000000,
        CTX_BSTAR   = 9'b100000000
    } ctx_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_SKIP  = 4'b0010,
        PH_MATCH = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    function automatic logic [7:0] marker_char(input logic kind, input logic [IDX_BITS-1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (kind == KIND_IGNORE) begin
            case (idx)
                4'd0:    ch = "m";
                4'd1:    ch = "c";
                4'd2:    ch = ":";
                4'd3:    ch = "i";
                4'd4:    ch = "g";
                4'd5:    ch = "n";
                4'd6:    ch = "o";
                4'd7:    ch = "r";
                4'd8:    ch = "e";
                default: ch = 8'h00;
            endcase
        end
        else begin
            case (idx)
                4'd0:    ch = "N";
                4'd1:    ch = "O";
                4'd2:    ch = "L";
                4'd3:    ch = "I";
                4'd4:    ch = "N";
                4'd5:    ch = "T";
                4'd6:    ch = "(";
                4'd7:    ch = "m";
                4'd8:    ch = "a";
                4'd9:    ch = "n";
                4'd10:   ch = "c";
                4'd11:   ch = "h";
                4'd12:   ch = "e";
                4'd13:   ch = "c";
                4'd14:   ch = "k";
                default: ch = ")";
            endcase
        end
        return ch;
    endfunction

    function automatic logic [POS_BITS-1:0] marker_len(input logic kind);
        return (kind == KIND_IGNORE) ? POS_BITS'(9) : POS_BITS'(16);
    endfunction

endpackage

### sv/c_comment_marker_scanner.sv
// Each accepted byte is held in the input register, and its result is registered on the master side.
// Throughput: one source byte per cycle while m_tready stays high; a pending
// result stalls the input register only until it is taken.
// Reset (rst_n low, asynchronous): lexer in code context, line count 1,
// no result pending. A byte with s_tlast returns the lexer to that state.
module c_comment_marker_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [ccms_pkg::LINE_NUM_BITS-1:0] m_tdata,  // [23:0] line_number
    output logic [1:0]  m_tuser    // [0] applies_to_next, [1] marker_kind
);
    import ccms_pkg::*;

    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
    localparam logic [LINE_NUM_BITS-1:0] NUM_MAX = '1;

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;

    ctx_t                 ctx_reg, ctx_next;
    phase_t               phase_reg, phase_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic                 blank_line_reg, blank_line_next;
    logic                 slash_blank_reg, slash_blank_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic                 choice_reg, choice_next;

    logic                 m_valid_reg;
    logic [LINE_NUM_BITS-1:0] m_line_reg, m_line_next;
    logic                 m_next_reg, m_next_next;
    logic                 m_kind_reg, m_kind_next;

    logic                 advance;
    logic                 emit;
    logic [7:0]           c;
    logic                 is_blank;
    logic [POS_BITS-1:0]  pos_inc;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_line_reg;
    assign m_tuser  = {m_kind_reg, m_next_reg};

    assign c        = in_byte_reg;
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB);
    assign pos_inc  = pos_reg + POS_BITS'(1);

    always_comb
    begin
        ctx_next         = ctx_reg;
        phase_next       = phase_reg;
        line_next        = line_reg;
        blank_line_next  = blank_line_reg;
        slash_blank_next = slash_blank_reg;
        pos_next         = pos_reg;
        choice_next      = choice_reg;
        emit             = 1'b0;
        m_kind_next      = choice_reg;
        m_next_next      = slash_blank_reg;
        if ((LINE_BITS > LINE_NUM_BITS) && (line_reg > LINE_BITS'(NUM_MAX))) begin
            m_line_next = NUM_MAX;
        end
        else begin
            m_line_next = LINE_NUM_BITS'(line_reg);
        end

        unique case (ctx_reg)
            CTX_STR:
            begin
                if (c == CH_BSLASH) ctx_next = CTX_STR_ESC;
                else if (c == CH_DQUOTE || c == CH_NL) ctx_next = CTX_CODE;
            end
            CTX_STR_ESC: ctx_next = CTX_STR;
            CTX_CHR:
            begin
                if (c == CH_BSLASH) ctx_next = CTX_CHR_ESC;
                else if (c == CH_SQUOTE || c == CH_NL) ctx_next = CTX_CODE;
            end
            CTX_CHR_ESC: ctx_next = CTX_CHR;
            CTX_LINE:
            begin
                if (c == CH_NL) begin
                    phase_next = PH_DONE;
                end
                else if (phase_reg == PH_SKIP) begin
                    if (!is_blank) begin
                        if (c == marker_char(KIND_IGNORE, '0)) begin
                            choice_next = KIND_IGNORE;
                            pos_next    = POS_BITS'(1);
                            phase_next  = PH_MATCH;
                        end
                        else if (c == marker_char(KIND_NOLINT, '0)) begin
                            choice_next = KIND_NOLINT;
                            pos_next    = POS_BITS'(1);
                            phase_next  = PH_MATCH;
                        end
                        else begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                else if (phase_reg == PH_MATCH) begin
                    if (c == marker_char(choice_reg, pos_reg[IDX_BITS-1:0])) begin
                        pos_next = pos_inc;
                        if (pos_inc >= marker_len(choice_reg)) begin
                            emit       = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                    else begin
                        phase_next = PH_DONE;
                    end
                end
            end
            CTX_BLOCK:
            begin
                if (c == CH_STAR) ctx_next = CTX_BSTAR;
            end
            CTX_BSTAR:
            begin
                if (c == CH_SLASH) ctx_next = CTX_CODE;
                else if (c != CH_STAR) ctx_next = CTX_BLOCK;
            end
            default:
            begin
                if (ctx_reg == CTX_SLASH && c == CH_SLASH) begin
                    ctx_next    = CTX_LINE;
                    phase_next  = PH_SKIP;
                    pos_next    = '0;
                    choice_next = 1'b0;
                end
                else if (ctx_reg == CTX_SLASH && c == CH_STAR) begin
                    ctx_next = CTX_BLOCK;
                end
                else if (c == CH_DQUOTE) begin
                    ctx_next = CTX_STR;
                end
                else if (c == CH_SQUOTE) begin
                    ctx_next = CTX_CHR;
                end
                else if (c == CH_SLASH) begin
                    ctx_next         = CTX_SLASH;
                    slash_blank_next = blank_line_reg;
                end
                else begin
                    ctx_next = CTX_CODE;
                end
            end
        endcase

        if (c == CH_NL) begin
            if (line_reg < LINE_MAX) line_next = line_reg + LINE_BITS'(1);
            if (ctx_next == CTX_LINE) begin
                ctx_next    = CTX_CODE;
                phase_next  = PH_IDLE;
                pos_next    = '0;
                choice_next = 1'b0;
            end
            blank_line_next = 1'b1;
        end
        else if (!is_blank) begin
            blank_line_next = 1'b0;
        end

        if (in_last_reg) begin
            ctx_next         = CTX_CODE;
            phase_next       = PH_IDLE;
            line_next        = LINE_BITS'(1);
            blank_line_next  = 1'b1;
            slash_blank_next = 1'b0;
            pos_next         = '0;
            choice_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            ctx_reg         <= CTX_CODE;
            phase_reg       <= PH_IDLE;
            line_reg        <= LINE_BITS'(1);
            blank_line_reg  <= 1'b1;
            slash_blank_reg <= 1'b0;
            pos_reg         <= '0;
            choice_reg      <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end
            else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                m_valid_reg     <= emit;
                ctx_reg         <= ctx_next;
                phase_reg       <= phase_next;
                line_reg        <= line_next;
                blank_line_reg  <= blank_line_next;
                slash_blank_reg <= slash_blank_next;
                pos_reg         <= pos_next;
                choice_reg      <= choice_next;
            end
            else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && emit) begin
            m_line_reg <= m_line_next;
            m_next_reg <= m_next_next;
            m_kind_reg <= m_kind_next;
        end
    end

endmodule

### verif/tb_c_comment_marker_scanner.sv
module tb_c_comment_marker_scanner;

    timeunit 1ns;
    timeprecision 1ps;

    import ccms_pkg::*;

    localparam int RANDOM_BYTES = 940;
    localparam int QUIET_AFTER  = 760;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 2000;

    localparam string TAG_IGNORE = "mc:ignore";
    localparam string TAG_NOLINT = "NOLINT(m\141ncheck)";

    typedef struct packed {
        logic [LINE_NUM_BITS-1:0] line;
        logic                     apply;
        logic                     kind;
    } marker_hit_t;

    typedef struct {
        string        txt;
        logic [7:0]   raw;
        bit           last;
        bit           typed;
        bit           hit;
        int unsigned  line;
        bit           apply;
        bit           kind;
    } dir_row_t;

    typedef enum int {
        FR_MARK,
        FR_PARTIAL,
        FR_STRING,
        FR_CHAR,
        FR_BLOCK,
        FR_NOISE,
        FR_NEWLINE
    } frag_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata = 8'h00;
    logic                      s_tlast = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [LINE_NUM_BITS-1:0]  m_tdata;
    logic [1:0]                m_tuser;

    c_comment_marker_scanner u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    string                 marker_tags[2] = '{TAG_IGNORE, TAG_NOLINT};
    ctx_t                  lex_ctx;
    phase_t                phase;
    logic [LINE_BITS-1:0]  line_cnt;
    bit                    blank_line;
    bit                    slash_blank;
    int                    mpos;
    logic                  mkind;

    marker_hit_t           expected_hits[$];
    logic [7:0]            frag_bytes[$];
    int                    errors = 0;
    int                    bytes_sent = 0;
    int                    eos_count = 0;
    int                    hits_seen = 0;
    int                    hold_asked = 0;
    int                    hold_done = 0;
    bit                    quiet = 1'b0;

    task automatic scanner_clear();
        lex_ctx     = CTX_CODE;
        phase       = PH_IDLE;
        line_cnt    = LINE_BITS'(1);
        blank_line  = 1'b1;
        slash_blank = 1'b0;
        mpos        = 0;
        mkind       = KIND_IGNORE;
    endtask

    function automatic ctx_t after_code(input logic [7:0] c);
        if (c == CH_DQUOTE)
            return CTX_STR;
        if (c == CH_SQUOTE)
            return CTX_CHR;
        if (c == CH_SLASH)
        begin
            slash_blank = blank_line;
            return CTX_SLASH;
        end
        return CTX_CODE;
    endfunction

    task automatic scan_byte(input logic [7:0] c, input bit last,
                             output bit hit, output marker_hit_t h);
        bit is_blank;
        is_blank = (c == CH_SPACE) || (c == CH_TAB);
        hit = 1'b0;
        h = '0;
        case (lex_ctx)
            CTX_STR:
            begin
                if (c == CH_BSLASH)
                    lex_ctx = CTX_STR_ESC;
                else if (c == CH_DQUOTE || c == CH_NL)
                    lex_ctx = CTX_CODE;
            end
            CTX_STR_ESC:
                lex_ctx = CTX_STR;
            CTX_CHR:
            begin
                if (c == CH_BSLASH)
                    lex_ctx = CTX_CHR_ESC;
                else if (c == CH_SQUOTE || c == CH_NL)
                    lex_ctx = CTX_CODE;
            end
            CTX_CHR_ESC:
                lex_ctx = CTX_CHR;
            CTX_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    lex_ctx = CTX_LINE;
                    phase   = PH_SKIP;
                    mpos    = 0;
                    mkind   = KIND_IGNORE;
                end
                else if (c == CH_STAR)
                    lex_ctx = CTX_BLOCK;
                else
                    lex_ctx = after_code(c);
            end
            CTX_LINE:
            begin
                if (c == CH_NL)
                    phase = PH_DONE;
                else if (phase == PH_SKIP)
                begin
                    if (!is_blank)
                    begin
                        if (c == marker_tags[KIND_IGNORE].getc(0))
                        begin
                            mkind = KIND_IGNORE;
                            mpos  = 1;
                            phase = PH_MATCH;
                        end
                        else if (c == marker_tags[KIND_NOLINT].getc(0))
                        begin
                            mkind = KIND_NOLINT;
                            mpos  = 1;
                            phase = PH_MATCH;
                        end
                        else
                            phase = PH_DONE;
                    end
                end
                else if (phase == PH_MATCH)
                begin
                    if (c == marker_tags[mkind].getc(mpos))
                    begin
                        mpos++;
                        if (mpos >= marker_tags[mkind].len())
                        begin
                            hit     = 1'b1;
                            h.line  = line_cnt;
                            h.apply = slash_blank;
                            h.kind  = mkind;
                            phase   = PH_DONE;
                        end
                    end
                    else
                        phase = PH_DONE;
                end
            end
            CTX_BLOCK:
            begin
                if (c == CH_STAR)
                    lex_ctx = CTX_BSTAR;
            end
            CTX_BSTAR:
            begin
                if (c == CH_SLASH)
                    lex_ctx = CTX_CODE;
                else if (c != CH_STAR)
                    lex_ctx = CTX_BLOCK;
            end
            default:
                lex_ctx = after_code(c);
        endcase

        if (c == CH_NL)
        begin
            if (line_cnt != '1)
                line_cnt++;
            if (lex_ctx == CTX_LINE)
            begin
                lex_ctx = CTX_CODE;
                phase   = PH_IDLE;
                mpos    = 0;
                mkind   = KIND_IGNORE;
            end
            blank_line = 1'b1;
        end
        else if (!is_blank)
            blank_line = 1'b0;

        if (last)
            scanner_clear();
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last, input bit predict);
        bit          hit;
        marker_hit_t h;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        scan_byte(b, last, hit, h);
        if (hit && predict)
            expected_hits.push_back(h);
        bytes_sent++;
        if (last)
            eos_count++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frag_bytes.push_back(s.getc(i));
    endtask

    task automatic put_blanks(input int n);
        for (int i = 0; i < n; i++)
            frag_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic build_fragment();
        int    r;
        int    n;
        frag_t kind;
        string tag;
        r = $urandom_range(0, 99);
        if (r < 35)
            kind = FR_MARK;
        else if (r < 50)
            kind = FR_PARTIAL;
        else if (r < 60)
            kind = FR_STRING;
        else if (r < 67)
            kind = FR_CHAR;
        else if (r < 77)
            kind = FR_BLOCK;
        else if (r < 92)
            kind = FR_NOISE;
        else
            kind = FR_NEWLINE;
        tag = marker_tags[$urandom_range(0, 1)];
        frag_bytes.delete();
        case (kind)
            FR_MARK:
            begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: put_blanks($urandom_range(1, 3));
                    2: put_text("i++; ");
                    default: put_text("\015");
                endcase
                put_text("//");
                put_blanks($urandom_range(0, 3));
                put_text(tag);
                if ($urandom_range(0, 2) == 0)
                    put_text(" mc:ignore */");
                if ($urandom_range(0, 4) != 0)
                    put_text("\n");
            end
            FR_PARTIAL:
            begin
                put_text("//");
                put_blanks($urandom_range(0, 2));
                n = $urandom_range(1, tag.len() - 1);
                for (int i = 0; i < n; i++)
                    frag_bytes.push_back(tag.getc(i));
                frag_bytes.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                    put_text("\n");
            end
            FR_STRING:
            begin
                put_text("\"");
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 5))
                        0: put_text("//mc:ignore");
                        1: put_text("\\\"");
                        default: frag_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
                    endcase
                end
                put_text($urandom_range(0, 3) == 0 ? "\n" : "\"");
            end
            FR_CHAR:
            begin
                if ($urandom_range(0, 1))
                    put_text("'\\''");
                else
                begin
                    put_text("'");
                    frag_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
                    put_text("'");
                end
            end
            FR_BLOCK:
            begin
                put_text("/*");
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 4))
                        0: put_text("*");
                        1: put_text("/");
                        2: put_text("//mc:ignore");
                        3: put_text("\n");
                        default: put_text(" x");
                    endcase
                end
                put_text("*/");
            end
            FR_NOISE:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    frag_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default:
                put_text("\n");
        endcase
    endtask

    always @(posedge clk)
    begin
        marker_hit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            hits_seen++;
            if (expected_hits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual line=%0d apply=%0b kind=%0b",
                         $time, m_tdata, m_tuser[0], m_tuser[1]);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (m_tdata !== want.line)
                begin
                    errors++;
                    $display("%0t: line_number mismatch: expected %0d, actual %0d",
                             $time, want.line, m_tdata);
                end
                if (m_tuser[0] !== want.apply)
                begin
                    errors++;
                    $display("%0t: applies_to_next mismatch: expected %0b, actual %0b",
                             $time, want.apply, m_tuser[0]);
                end
                if (m_tuser[1] !== want.kind)
                begin
                    errors++;
                    $display("%0t: marker_kind mismatch: expected %0b, actual %0b",
                             $time, want.kind, m_tuser[1]);
                end
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_asked)
            begin
                hold_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        dir_row_t    dir_rows[19];
        marker_hit_t h;
        int          n;
        int          random_start;
        int          drain;

        dir_rows = '{
            '{"//mc:ignore",                         8'h00, 0, 1, 1, 1,  1, KIND_IGNORE},
            '{" trailing text\n",                    8'h00, 0, 1, 0, 0,  0, KIND_IGNORE},
            '{"x = 1; //\t NOLINT(m\141ncheck)",     8'h00, 0, 1, 1, 2,  0, KIND_NOLINT},
            '{"\n\"a\\\"//mc:ignore\" 'b' '\\'' x\n", 8'h00, 0, 0, 0, 0,  0, KIND_IGNORE},
            '{"/* //mc:ignore **/ //mc:ignor\n",     8'h00, 0, 1, 0, 0,  0, KIND_IGNORE},
            '{"\"open string\n//mc:ignore",          8'h00, 0, 1, 1, 6,  1, KIND_IGNORE},
            '{"\n\015//mc:ignore",                   8'h00, 0, 1, 1, 7,  0, KIND_IGNORE},
            '{"\n// mc:ignorx\n",                    8'h00, 0, 0, 0, 0,  0, KIND_IGNORE},
            '{"/ /mc:ignore\n",                      8'h00, 0, 0, 0, 0,  0, KIND_IGNORE},
            '{"'\\'//mc:ignore'\n",                  8'h00, 0, 0, 0, 0,  0, KIND_IGNORE},
            '{"a //mc:ignore",                       8'h00, 1, 1, 1, 11, 0, KIND_IGNORE},
            '{"\n\n  //NOLINT(m\141ncheck)",         8'h00, 1, 1, 1, 3,  1, KIND_NOLINT},
            '{"",                                    8'h00, 0, 0, 0, 0,  0, KIND_IGNORE},
            '{"",                                    8'hff, 0, 0, 0, 0,  0, KIND_IGNORE},
            '{"//\t\t  mc:ignore more\n",            8'h00, 0, 0, 0, 0,  0, KIND_IGNORE},
            '{"//NOLINT(m\141nchecK)\n",             8'h00, 0, 0, 0, 0,  0, KIND_IGNORE},
            '{"/*/ //mc:ignore*/ x //NOLINT(m\141ncheck) //mc:ignore\n",
                                                     8'h00, 0, 0, 0, 0,  0, KIND_IGNORE},
            '{"\"\\\n//mc:ignore\n",                 8'h00, 0, 0, 0, 0,  0, KIND_IGNORE},
            '{"x\n",                                 8'h00, 1, 0, 0, 0,  0, KIND_IGNORE}
        };

        scanner_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            n = dir_rows[i].txt.len();
            if (n == 0)
                send_byte(dir_rows[i].raw, dir_rows[i].last, !dir_rows[i].typed);
            else
                for (int j = 0; j < n; j++)
                    send_byte(dir_rows[i].txt.getc(j), dir_rows[i].last && j == n - 1,
                              !dir_rows[i].typed);
            if (dir_rows[i].typed && dir_rows[i].hit)
            begin
                h.line  = LINE_NUM_BITS'(dir_rows[i].line);
                h.apply = dir_rows[i].apply;
                h.kind  = dir_rows[i].kind;
                expected_hits.push_back(h);
            end
        end

        random_start = bytes_sent;
        hold_asked++;
        for (int k = 0; k < 6; k++)
        begin
            frag_bytes.delete();
            put_text("//mc:ignore\n");
            foreach (frag_bytes[j])
                send_byte(frag_bytes[j], 1'b0, 1'b1);
        end

        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            if (bytes_sent - random_start >= QUIET_AFTER)
                quiet = 1'b1;
            build_fragment();
            n = int'($urandom_range(0, 29) == 0);
            foreach (frag_bytes[j])
                send_byte(frag_bytes[j], n != 0 && j == frag_bytes.size() - 1, 1'b1);
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (expected_hits.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (expected_hits.size() != 0)
        begin
            errors++;
            $display("%0t: %0d marker results never arrived", $time, expected_hits.size());
        end

        $display("Scanned %0d source bytes with %0d end-of-source marks;", bytes_sent, eos_count);
        $display("%0d marker results compared, %0d mismatches.", hits_seen, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
